// ===== rtl/hct_pkg.sv =====
// Package for the HHMMSS countdown timer: command codes, BCD state type,
// digit positions and the helper functions used by the datapath modules.
// No dependencies.
package hct_pkg;

    localparam int NUM_DIGITS = 6;
    localparam int VALUE_W    = 20;
    localparam int SEG_W      = 7;

    localparam int IDX_SEC_ONES  = 0;
    localparam int IDX_SEC_TENS  = 1;
    localparam int IDX_MIN_ONES  = 2;
    localparam int IDX_MIN_TENS  = 3;
    localparam int IDX_HOUR_ONES = 4;
    localparam int IDX_HOUR_TENS = 5;

    typedef logic [3:0]       bcd_t;
    typedef logic [SEG_W-1:0] seg_t;

    typedef enum logic [1:0] {
        CMD_DIGIT = 2'd0,
        CMD_STOP  = 2'd1,
        CMD_START = 2'd2,
        CMD_TICK  = 2'd3
    } cmd_t;

    typedef struct packed {
        bcd_t [NUM_DIGITS-1:0] digits;
        logic                  run;
    } hct_state_t;

    localparam bcd_t BCD_ZERO = 4'd0;
    localparam bcd_t BCD_FIVE = 4'd5;
    localparam bcd_t BCD_NINE = 4'd9;

    // Decimal decrement of a two-digit pair; 00 wraps to 59.
    function automatic logic [7:0] pair_dec(input bcd_t tens, input bcd_t ones);
        logic [7:0] r;
        if (ones != BCD_ZERO)
            r = {tens, ones - 4'd1};
        else if (tens != BCD_ZERO)
            r = {tens - 4'd1, BCD_NINE};
        else
            r = {BCD_FIVE, BCD_NINE};
        return r;
    endfunction

    // Two BCD digits to binary 0..99.
    function automatic logic [6:0] pair_bin(input bcd_t tens, input bcd_t ones);
        return {tens, 3'b000} + {2'b00, tens, 1'b0} + {3'b000, ones};
    endfunction

    // Segments gfedcba; codes above nine are blank.
    function automatic seg_t seg_decode(input bcd_t d);
        seg_t s;
        unique case (d)
            4'd0:    s = 7'h3F;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5B;
            4'd3:    s = 7'h4F;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6D;
            4'd6:    s = 7'h7D;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h6F;
            default: s = 7'h00;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/hct_next.sv =====
// Next-state logic of the countdown timer: digit entry, stop/clear, start
// and the BCD decrement with 59 borrow. Depends on hct_pkg.
module hct_next import hct_pkg::*;
(
    input  hct_state_t state,
    input  cmd_t       cmd,
    input  bcd_t       digit,
    output hct_state_t state_next,
    output logic       alarm
);

    logic       is_zero;
    logic       sec_borrow;
    logic       min_borrow;
    logic [7:0] sec_dec;
    logic [7:0] min_dec;
    logic [7:0] hour_dec;
    bcd_t [NUM_DIGITS-1:0] dec_digits;

    always_comb
    begin
        is_zero    = (state.digits == '0);
        sec_borrow = (state.digits[IDX_SEC_TENS] == BCD_ZERO) &&
                     (state.digits[IDX_SEC_ONES] == BCD_ZERO);
        min_borrow = sec_borrow &&
                     (state.digits[IDX_MIN_TENS] == BCD_ZERO) &&
                     (state.digits[IDX_MIN_ONES] == BCD_ZERO);
        sec_dec  = pair_dec(state.digits[IDX_SEC_TENS], state.digits[IDX_SEC_ONES]);
        min_dec  = pair_dec(state.digits[IDX_MIN_TENS], state.digits[IDX_MIN_ONES]);
        hour_dec = pair_dec(state.digits[IDX_HOUR_TENS], state.digits[IDX_HOUR_ONES]);

        dec_digits = state.digits;
        {dec_digits[IDX_SEC_TENS], dec_digits[IDX_SEC_ONES]} = sec_dec;
        if (sec_borrow)
        begin
            {dec_digits[IDX_MIN_TENS], dec_digits[IDX_MIN_ONES]} = min_dec;
        end
        if (min_borrow)
        begin
            {dec_digits[IDX_HOUR_TENS], dec_digits[IDX_HOUR_ONES]} = hour_dec;
        end

        state_next = state;
        alarm      = 1'b0;
        unique case (cmd)
            CMD_DIGIT:
            begin
                if (!state.run && digit <= BCD_NINE)
                begin
                    state_next.digits = {state.digits[NUM_DIGITS-2:0], digit};
                end
            end
            CMD_STOP:
            begin
                if (state.run)
                    state_next.run = 1'b0;
                else
                    state_next.digits = '0;
            end
            CMD_START:
            begin
                state_next.run = 1'b1;
            end
            CMD_TICK:
            begin
                if (state.run)
                begin
                    if (!is_zero)
                    begin
                        state_next.digits = dec_digits;
                        alarm = (dec_digits == '0);
                    end
                    else
                    begin
                        alarm = 1'b1;
                    end
                end
            end
        endcase
    end

endmodule

// ===== rtl/hct_disp.sv =====
// Display and value conversion: six seven-segment patterns and the binary
// HHMMSS value from the BCD digits. Depends on hct_pkg.
module hct_disp import hct_pkg::*;
(
    input  hct_state_t           state,
    output seg_t [NUM_DIGITS-1:0] segs,
    output logic [VALUE_W-1:0]    value
);

    logic [6:0] hh;
    logic [6:0] mm;
    logic [6:0] ss;

    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            segs[i] = seg_decode(state.digits[i]);
        end
        hh = pair_bin(state.digits[IDX_HOUR_TENS], state.digits[IDX_HOUR_ONES]);
        mm = pair_bin(state.digits[IDX_MIN_TENS], state.digits[IDX_MIN_ONES]);
        ss = pair_bin(state.digits[IDX_SEC_TENS], state.digits[IDX_SEC_ONES]);
        value = VALUE_W'(hh) * VALUE_W'(10000)
              + VALUE_W'(mm) * VALUE_W'(100)
              + VALUE_W'(ss);
    end

endmodule

// ===== rtl/hhmmss_countdown_timer_top.sv =====
// HHMMSS countdown timer top level: input register, timer state, result
// register. Depends on hct_pkg, hct_next and hct_disp.
// The input register holds each command until the result register can take its result.
// Throughput: one transaction per cycle while the receiver keeps out_ready high;
// a stalled result holds the input register, and in_ready then drops.
// Reset (rst_n low, async): time cleared to zero, timer idle, both stages empty.
module hhmmss_countdown_timer_top import hct_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          cmd,
    input  logic [3:0]          digit,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [SEG_W-1:0]    seg_hour_tens,
    output logic [SEG_W-1:0]    seg_hour_ones,
    output logic [SEG_W-1:0]    seg_min_tens,
    output logic [SEG_W-1:0]    seg_min_ones,
    output logic [SEG_W-1:0]    seg_sec_tens,
    output logic [SEG_W-1:0]    seg_sec_ones,
    output logic [VALUE_W-1:0]  time_value,
    output logic                running,
    output logic                alarm
);

    logic                   in_valid_reg;
    cmd_t                   cmd_reg;
    bcd_t                   digit_reg;
    hct_state_t             state_reg;
    hct_state_t             state_next;
    logic                   alarm_next;
    logic                   out_valid_reg;
    seg_t [NUM_DIGITS-1:0]  segs_next;
    seg_t [NUM_DIGITS-1:0]  segs_reg;
    logic [VALUE_W-1:0]     value_next;
    logic [VALUE_W-1:0]     value_reg;
    logic                   running_reg;
    logic                   alarm_reg;
    logic                   advance;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || !out_valid_reg || out_ready;

    hct_next u_next (
        .state      (state_reg),
        .cmd        (cmd_reg),
        .digit      (digit_reg),
        .state_next (state_next),
        .alarm      (alarm_next)
    );

    hct_disp u_disp (
        .state (state_next),
        .segs  (segs_next),
        .value (value_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg   <= cmd_t'(cmd);
            digit_reg <= digit;
        end
        if (advance)
        begin
            segs_reg    <= segs_next;
            value_reg   <= value_next;
            running_reg <= state_next.run;
            alarm_reg   <= alarm_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign seg_hour_tens = segs_reg[IDX_HOUR_TENS];
    assign seg_hour_ones = segs_reg[IDX_HOUR_ONES];
    assign seg_min_tens  = segs_reg[IDX_MIN_TENS];
    assign seg_min_ones  = segs_reg[IDX_MIN_ONES];
    assign seg_sec_tens  = segs_reg[IDX_SEC_TENS];
    assign seg_sec_ones  = segs_reg[IDX_SEC_ONES];
    assign time_value    = value_reg;
    assign running       = running_reg;
    assign alarm         = alarm_reg;

endmodule

// ===== tb/hct_checker.sv =====
// Checker for the HHMMSS countdown timer: watches both channels, predicts each
// result from its own copy of the timer state and compares field by field.
// Depends on hct_pkg.
module hct_checker import hct_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [1:0]         cmd,
    input  logic [3:0]         digit,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [SEG_W-1:0]   seg_hour_tens,
    input  logic [SEG_W-1:0]   seg_hour_ones,
    input  logic [SEG_W-1:0]   seg_min_tens,
    input  logic [SEG_W-1:0]   seg_min_ones,
    input  logic [SEG_W-1:0]   seg_sec_tens,
    input  logic [SEG_W-1:0]   seg_sec_ones,
    input  logic [VALUE_W-1:0] time_value,
    input  logic               running,
    input  logic               alarm,
    output int                 fail_count,
    output int                 outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned HOUR_STEP   = 10000;
    localparam int unsigned HOUR_BORROW = 4000;
    localparam int unsigned MIN_STEP    = 100;
    localparam int unsigned MIN_BORROW  = 40;
    localparam int unsigned TIME_WRAP   = 1000000;

    typedef struct packed {
        seg_t [NUM_DIGITS-1:0] seg;
        logic [VALUE_W-1:0]    value;
        logic                  run;
        logic                  alarm;
    } timer_view_t;

    int unsigned   time_now;
    logic          run_now;
    timer_view_t   pending_views[$];
    int            result_no;

    initial
    begin
        fail_count  = 0;
        outstanding = 0;
        time_now    = 0;
        run_now     = 1'b0;
        result_no   = 0;
    end

    function automatic seg_t glyph_of(input int unsigned d);
        case (d)
            0:       return 7'h3F;
            1:       return 7'h06;
            2:       return 7'h5B;
            3:       return 7'h4F;
            4:       return 7'h66;
            5:       return 7'h6D;
            6:       return 7'h7D;
            7:       return 7'h07;
            8:       return 7'h7F;
            9:       return 7'h6F;
            default: return 7'h00;
        endcase
    endfunction

    function automatic timer_view_t advance_timer(input cmd_t c, input bcd_t d);
        timer_view_t view;
        int unsigned v;
        int unsigned scale;
        logic        rang;
        v     = time_now;
        rang  = 1'b0;
        case (c)
            CMD_DIGIT:
                if (!run_now && d <= BCD_NINE)
                    v = (v * 10 + d) % TIME_WRAP;
            CMD_STOP:
                if (run_now)
                    run_now = 1'b0;
                else
                    v = 0;
            CMD_START:
                run_now = 1'b1;
            default:
                if (run_now)
                begin
                    if (v != 0)
                    begin
                        if (v % HOUR_STEP == 0)
                            v = v - HOUR_BORROW;
                        if (v % MIN_STEP == 0)
                            v = v - MIN_BORROW;
                        v = v - 1;
                    end
                    if (v == 0)
                        rang = 1'b1;
                end
        endcase
        time_now = v;
        scale    = 1;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            view.seg[i] = glyph_of((v / scale) % 10);
            scale       = scale * 10;
        end
        view.value = v[VALUE_W-1:0];
        view.run   = run_now;
        view.alarm = rang;
        return view;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch at result %0d, %s: got 0x%0h, expected 0x%0h",
                 result_no, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        timer_view_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_views.size() == 0)
                    report_mismatch("result with no transaction pending", 0, 0);
                else
                begin
                    want = pending_views.pop_front();
                    if (seg_hour_tens !== want.seg[IDX_HOUR_TENS])
                        report_mismatch("seg_hour_tens", seg_hour_tens, want.seg[IDX_HOUR_TENS]);
                    if (seg_hour_ones !== want.seg[IDX_HOUR_ONES])
                        report_mismatch("seg_hour_ones", seg_hour_ones, want.seg[IDX_HOUR_ONES]);
                    if (seg_min_tens !== want.seg[IDX_MIN_TENS])
                        report_mismatch("seg_min_tens", seg_min_tens, want.seg[IDX_MIN_TENS]);
                    if (seg_min_ones !== want.seg[IDX_MIN_ONES])
                        report_mismatch("seg_min_ones", seg_min_ones, want.seg[IDX_MIN_ONES]);
                    if (seg_sec_tens !== want.seg[IDX_SEC_TENS])
                        report_mismatch("seg_sec_tens", seg_sec_tens, want.seg[IDX_SEC_TENS]);
                    if (seg_sec_ones !== want.seg[IDX_SEC_ONES])
                        report_mismatch("seg_sec_ones", seg_sec_ones, want.seg[IDX_SEC_ONES]);
                    if (time_value !== want.value)
                        report_mismatch("time_value", time_value, want.value);
                    if (running !== want.run)
                        report_mismatch("running", running, want.run);
                    if (alarm !== want.alarm)
                        report_mismatch("alarm", alarm, want.alarm);
                end
                result_no++;
            end
            if (in_valid && in_ready)
                pending_views.push_back(advance_timer(cmd_t'(cmd), digit));
            outstanding = pending_views.size();
        end
    end

endmodule

// ===== tb/hhmmss_countdown_timer_top_test.sv =====
// Testbench top for the HHMMSS countdown timer: clock, reset, bursty command
// stimulus, a stalling result receiver and the verdict.
// Depends on hct_pkg, hhmmss_countdown_timer_top and hct_checker.
module hhmmss_countdown_timer_top_test;
    import hct_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 650;
    localparam int HOLD_OFF_LEN  = 80;
    localparam int DRAIN_CYCLES  = 10;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    logic [1:0]         cmd       = CMD_DIGIT;
    logic [3:0]         digit     = 4'd0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [SEG_W-1:0]   seg_hour_tens, seg_hour_ones, seg_min_tens;
    logic [SEG_W-1:0]   seg_min_ones, seg_sec_tens, seg_sec_ones;
    logic [VALUE_W-1:0] time_value;
    logic               running;
    logic               alarm;

    int          fail_count;
    int          outstanding;
    int          cycle_count = 0;
    int          burst_left  = 0;
    int          sent_count  = 0;
    logic        hold_req    = 1'b0;
    logic        hold_taken  = 1'b0;
    int          hold_left   = 0;
    int unsigned rx_mode     = 0;
    int          rx_left     = 0;

    always #6 clk = ~clk;

    hhmmss_countdown_timer_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .digit         (digit),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .seg_hour_tens (seg_hour_tens),
        .seg_hour_ones (seg_hour_ones),
        .seg_min_tens  (seg_min_tens),
        .seg_min_ones  (seg_min_ones),
        .seg_sec_tens  (seg_sec_tens),
        .seg_sec_ones  (seg_sec_ones),
        .time_value    (time_value),
        .running       (running),
        .alarm         (alarm)
    );

    hct_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .digit         (digit),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .seg_hour_tens (seg_hour_tens),
        .seg_hour_ones (seg_hour_ones),
        .seg_min_tens  (seg_min_tens),
        .seg_min_ones  (seg_min_ones),
        .seg_sec_tens  (seg_sec_tens),
        .seg_sec_ones  (seg_sec_ones),
        .time_value    (time_value),
        .running       (running),
        .alarm         (alarm),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: random stall patterns, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req && !hold_taken)
        begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_OFF_LEN;
            out_ready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode <= $urandom_range(0, 3);
                rx_left <= $urandom_range(8, 40);
            end
            else
                rx_left <= rx_left - 1;
            case (rx_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(0, 1) != 0);
                2:       out_ready <= ($urandom_range(0, 3) != 0);
                default: out_ready <= (cycle_count % 3 == 0);
            endcase
        end
    end

    task automatic send_command(input cmd_t c, input logic [3:0] d);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 10);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        digit    <= d;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        burst_left--;
        sent_count++;
    endtask

    initial
    begin
        int unsigned n_keys;
        int unsigned n_ticks;
        logic [3:0]  key;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        send_command(CMD_TICK, 4'd0);
        send_command(CMD_START, 4'd0);
        send_command(CMD_TICK, 4'd0);
        send_command(CMD_TICK, 4'd0);
        send_command(CMD_DIGIT, 4'd7);
        send_command(CMD_START, 4'd0);
        send_command(CMD_STOP, 4'd0);
        send_command(CMD_STOP, 4'd0);
        repeat (6) send_command(CMD_DIGIT, 4'd9);
        send_command(CMD_DIGIT, 4'd15);
        send_command(CMD_DIGIT, 4'd10);
        send_command(CMD_START, 4'd0);
        send_command(CMD_TICK, 4'd0);
        send_command(CMD_STOP, 4'd0);
        send_command(CMD_STOP, 4'd0);
        send_command(CMD_DIGIT, 4'd1);
        repeat (4) send_command(CMD_DIGIT, 4'd0);
        send_command(CMD_START, 4'd0);
        send_command(CMD_TICK, 4'd0);

        // long receiver hold-off while the sender keeps offering
        hold_req   <= 1'b1;
        burst_left = 40;

        while (sent_count < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                send_command(CMD_STOP, 4'd0);
                send_command(CMD_STOP, 4'd0);
                n_keys = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 7)
                                                      : $urandom_range(1, 3);
                repeat (n_keys)
                begin
                    key = ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(0, 9));
                    send_command(CMD_DIGIT, key);
                    if ($urandom_range(0, 9) == 0)
                        send_command(CMD_DIGIT, 4'($urandom_range(10, 15)));
                end
                send_command(CMD_START, 4'd0);
                n_ticks = $urandom_range(1, 30);
                repeat (n_ticks)
                begin
                    if ($urandom_range(0, 14) == 0)
                        send_command(cmd_t'($urandom_range(0, 3)),
                                     4'($urandom_range(0, 15)));
                    else
                        send_command(CMD_TICK, 4'($urandom_range(0, 15)));
                end
                if ($urandom_range(0, 1) == 0)
                    send_command(CMD_STOP, 4'd0);
            end
            else
                repeat ($urandom_range(1, 5))
                    send_command(cmd_t'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/hct_pkg.sv
rtl/hct_next.sv
rtl/hct_disp.sv
rtl/hhmmss_countdown_timer_top.sv
tb/hct_checker.sv
tb/hhmmss_countdown_timer_top_test.sv
